@@ design/pfs_pkg.sv @@
package pfs_pkg;

  localparam int NUM_LEVELS  = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_BITS   = 8;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  typedef logic [LVL_W-1:0]     lvl_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [TASK_BITS-1:0] task_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_PRI = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_e;

  // Per-level queue bookkeeping held in the control memory.
  typedef struct packed {
    ptr_t head;
    ptr_t tail;
    cnt_t count;
  } ctrl_t;

  typedef struct packed {
    logic  en;
    lvl_t  addr;
    ctrl_t data;
  } ctrl_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    task_t data;
  } task_wr_t;

  function automatic ptr_t advance(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic addr_t slot_addr(lvl_t lvl, ptr_t p);
    return addr_t'(addr_t'(lvl) * addr_t'(QUEUE_DEPTH) + addr_t'(p));
  endfunction

endpackage

@@ design/pfs_cmd_if.sv @@
interface pfs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] priority_req;
  logic [7:0] task_id;

  modport source (output valid, mode, priority_req, task_id, input ready);
  modport sink   (input valid, mode, priority_req, task_id, output ready);
endinterface

@@ design/pfs_rsp_if.sv @@
interface pfs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       next_valid;
  logic [7:0] next_task;
  logic [5:0] next_priority;

  modport source (output valid, status, next_valid, next_task, next_priority,
                  input ready);
  modport sink   (input valid, status, next_valid, next_task, next_priority,
                  output ready);
endinterface

@@ design/pfs_ctrl_mem.sv @@
// Per-level head, tail and count. Entries never written read as zero.
module pfs_ctrl_mem
  import pfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rd_en_i,
  input  lvl_t     rd_addr_i,
  output ctrl_t    rd_data_o,
  input  ctrl_wr_t wr_i
);

  ctrl_t                 mem_q [NUM_LEVELS];
  ctrl_t                 rd_data_q;
  logic [NUM_LEVELS-1:0] written_q;
  logic                  rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

@@ design/pfs_task_mem.sv @@
// Task identifier store, one slot range per level.
module pfs_task_mem
  import pfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rd_en_i,
  input  addr_t    rd_addr_i,
  output task_t    rd_data_o,
  input  task_wr_t wr_i
);

  task_t mem_q [SLOTS];
  task_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/priority_fifo_scheduler.sv @@
// Multilevel priority FIFO scheduler. Each command transaction adds a task at
// the tail of a level, moves a level's head task to its tail, or removes a
// level's head; mode 3 changes nothing and simply reports. Every command
// yields exactly one response transaction carrying the status (ok, invalid
// priority, full, empty) and the head task of the most urgent non-empty level,
// where level 0 is the most urgent. An add to a full level or a rotate/remove
// on an empty level is flagged and leaves the queues untouched. A command is
// handled one at a time: after acceptance it steps through EXEC, ROT_WR (rotate
// only), FIND and FETCH to RESP, where the response is loaded once the
// response slot is free; the next command is accepted in the cycle after the
// response is loaded, even if that response has not yet been taken downstream.
// This sequencing comes from two single-read-port memories with registered
// reads: the per-level control memory is read once for the addressed level and
// once for the winning level, and the task store is read for the rotated head
// and for the reported head. No clearing pass is needed after reset; the
// control memory carries a valid bit per level.
module priority_fifo_scheduler
  import pfs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pfs_cmd_if.sink   cmd_i,
  pfs_rsp_if.source rsp_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_ROT_WR = 6'b000100,
    ST_FIND   = 6'b001000,
    ST_FETCH  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Command captured at acceptance.
  mode_e   mode_q;
  lvl_t    lvl_q;
  logic    pri_ok_q;
  task_t   task_q;

  // Working registers.
  status_e status_q, status_d;
  ctrl_t   ctrl_q, ctrl_d;
  lvl_t    win_q, win_d;
  logic    any_q, any_d;
  logic [NUM_LEVELS-1:0] mask_q, mask_d;

  // Response register.
  logic    rsp_valid_q, rsp_valid_d;
  status_e rsp_status_q;
  logic    rsp_next_valid_q;
  logic [7:0] rsp_task_q;
  logic [5:0] rsp_pri_q;
  logic    rsp_load;

  // Memory ports.
  logic     ctrl_rd_en;
  lvl_t     ctrl_rd_addr;
  ctrl_t    ctrl_rd_data;
  ctrl_wr_t ctrl_wr;
  logic     task_rd_en;
  addr_t    task_rd_addr;
  task_t    task_rd_data;
  task_wr_t task_wr;

  logic       cmd_accept;

  pfs_ctrl_mem u_ctrl_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ctrl_rd_en),
    .rd_addr_i (ctrl_rd_addr),
    .rd_data_o (ctrl_rd_data),
    .wr_i      (ctrl_wr)
  );

  pfs_task_mem u_task_mem (
    .clk_i     (clk_i),
    .rd_en_i   (task_rd_en),
    .rd_addr_i (task_rd_addr),
    .rd_data_o (task_rd_data),
    .wr_i      (task_wr)
  );

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_accept  = cmd_i.valid && cmd_i.ready;

  // The response slot is free when empty or being drained this cycle.
  assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_o.ready);

  // Lowest set bit of the non-empty mask picks the most urgent level.
  always_comb begin
    win_d = '0;
    any_d = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        win_d = LVL_W'(i);
        any_d = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    ctrl_d       = ctrl_q;
    mask_d       = mask_q;
    ctrl_rd_en   = 1'b0;
    ctrl_rd_addr = win_d;
    task_rd_en   = 1'b0;
    task_rd_addr = slot_addr(win_q, ctrl_rd_data.head);
    ctrl_wr      = '0;
    task_wr      = '0;

    unique case (state_q)
      ST_IDLE: begin
        ctrl_rd_addr = cmd_i.priority_req[LVL_W-1:0];
        if (cmd_accept) begin
          ctrl_rd_en = 1'b1;
          state_d    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // Control entry of the addressed level is now on the read port.
        state_d  = ST_FIND;
        status_d = STATUS_OK;
        ctrl_d   = ctrl_rd_data;
        if (mode_q != MODE_QUERY) begin
          if (!pri_ok_q) begin
            status_d = STATUS_BAD_PRI;
          end else if (mode_q == MODE_ADD) begin
            if (ctrl_rd_data.count >= CNT_W'(QUEUE_DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              task_wr.en        = 1'b1;
              task_wr.addr      = slot_addr(lvl_q, ctrl_rd_data.tail);
              task_wr.data      = task_q;
              ctrl_wr.en        = 1'b1;
              ctrl_wr.addr      = lvl_q;
              ctrl_wr.data      = ctrl_rd_data;
              ctrl_wr.data.tail = advance(ctrl_rd_data.tail);
              ctrl_wr.data.count = cnt_t'(ctrl_rd_data.count + 1'b1);
              mask_d[lvl_q]     = 1'b1;
            end
          end else if (ctrl_rd_data.count == '0) begin
            status_d = STATUS_EMPTY;
          end else if (mode_q == MODE_ROTATE) begin
            // Fetch the head task; it is written at the tail next cycle.
            task_rd_en   = 1'b1;
            task_rd_addr = slot_addr(lvl_q, ctrl_rd_data.head);
            state_d      = ST_ROT_WR;
          end else begin
            ctrl_wr.en         = 1'b1;
            ctrl_wr.addr       = lvl_q;
            ctrl_wr.data       = ctrl_rd_data;
            ctrl_wr.data.head  = advance(ctrl_rd_data.head);
            ctrl_wr.data.count = cnt_t'(ctrl_rd_data.count - 1'b1);
            if (ctrl_rd_data.count == cnt_t'(1)) begin
              mask_d[lvl_q] = 1'b0;
            end
          end
        end
      end

      ST_ROT_WR: begin
        task_wr.en        = 1'b1;
        task_wr.addr      = slot_addr(lvl_q, ctrl_q.tail);
        task_wr.data      = task_rd_data;
        ctrl_wr.en        = 1'b1;
        ctrl_wr.addr      = lvl_q;
        ctrl_wr.data      = ctrl_q;
        ctrl_wr.data.head = advance(ctrl_q.head);
        ctrl_wr.data.tail = advance(ctrl_q.tail);
        state_d           = ST_FIND;
      end

      ST_FIND: begin
        // The mask and memories already reflect this command.
        ctrl_rd_en = 1'b1;
        state_d    = ST_FETCH;
      end

      ST_FETCH: begin
        task_rd_en = 1'b1;
        state_d    = ST_RESP;
      end

      ST_RESP: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      mode_q   <= mode_e'(cmd_i.mode);
      lvl_q    <= cmd_i.priority_req[LVL_W-1:0];
      pri_ok_q <= ({1'b0, cmd_i.priority_req} < 7'(NUM_LEVELS));
      task_q   <= task_t'(cmd_i.task_id);
    end
    status_q <= status_d;
    ctrl_q   <= ctrl_d;
    if (state_q == ST_FIND) begin
      win_q <= win_d;
      any_q <= any_d;
    end
    if (rsp_load) begin
      rsp_status_q     <= status_q;
      rsp_next_valid_q <= any_q;
      rsp_task_q       <= any_q ? 8'(task_rd_data) : 8'd0;
      rsp_pri_q        <= any_q ? 6'(win_q) : 6'd0;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.next_valid    = rsp_next_valid_q;
  assign rsp_o.next_task     = rsp_task_q;
  assign rsp_o.next_priority = rsp_pri_q;

endmodule
